@@ rtl/rpb_pkg.sv @@
// Package for the RGBA8888 pixel blend unit: pixel request/response types,
// blend mode codes and the divide-by-255 helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpb_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned MODE_W = 3;

   localparam logic [MODE_W-1:0] MODE_ALPHA    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COPY     = 3'd4;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef struct packed {
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_alpha;
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
   } pixel_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_alpha;
   } pixel_rsp_type;

   // floor(x / 255), exact for x <= 65279
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
      logic [2*CHAN_W:0] t;
      t = {1'b0, x} + {9'd0, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

`default_nettype wire

@@ rtl/rgba_pixel_blend_unit.sv @@
// Top level of the RGBA8888 pixel blend unit: request register, blend datapath,
// response register and the mode register. Depends on rpb_pkg, rpb_color_mix, rpb_alpha_mix.
`timescale 1ns / 1ps
`default_nettype none

// Blends one destination and one source RGBA8888 pixel per request under the
// mode held in the one CSR (reset: copy source). Throughput is one pixel per
// clock while req_stall is low; a request passes from the request register
// to the response register through the single pass of multiply, divide-by-255
// and saturate logic. req_stall follows rsp_stall combinationally when both
// registers are full. Write the mode only while no request is in flight.
module rgba_pixel_blend_unit import rpb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire pixel_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output pixel_rsp_type      rsp_data,
   input  wire logic          csr_write_enable,
   input  wire logic [MODE_W-1:0] csr_write_data
);

   logic [MODE_W-1:0] mode_ff;
   logic              s1_valid_ff, s1_valid_in;
   pixel_req_type     s1_data_ff, s1_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pixel_rsp_type     rsp_data_ff, rsp_data_in;
   pixel_rsp_type     mixed;
   logic              out_hold;
   logic              s1_hold;

   rpb_color_mix u_red (
      .mode(mode_ff), .dst(s1_data_ff.dst_red), .dst_alpha(s1_data_ff.dst_alpha),
      .src(s1_data_ff.src_red), .src_alpha(s1_data_ff.src_alpha), .result(mixed.out_red)
   );

   rpb_color_mix u_green (
      .mode(mode_ff), .dst(s1_data_ff.dst_green), .dst_alpha(s1_data_ff.dst_alpha),
      .src(s1_data_ff.src_green), .src_alpha(s1_data_ff.src_alpha),
      .result(mixed.out_green)
   );

   rpb_color_mix u_blue (
      .mode(mode_ff), .dst(s1_data_ff.dst_blue), .dst_alpha(s1_data_ff.dst_alpha),
      .src(s1_data_ff.src_blue), .src_alpha(s1_data_ff.src_alpha), .result(mixed.out_blue)
   );

   rpb_alpha_mix u_alpha (
      .mode(mode_ff), .dst_alpha(s1_data_ff.dst_alpha), .src_alpha(s1_data_ff.src_alpha),
      .result(mixed.out_alpha)
   );

   always_comb begin
      out_hold     = rsp_valid_ff && rsp_stall;
      s1_hold      = s1_valid_ff && out_hold;
      req_stall    = s1_hold;
      s1_valid_in  = s1_hold ? s1_valid_ff : req_valid;
      s1_data_in   = (!s1_hold && req_valid) ? req_data : s1_data_ff;
      rsp_valid_in = out_hold ? rsp_valid_ff : s1_valid_ff;
      rsp_data_in  = (!out_hold && s1_valid_ff) ? mixed : rsp_data_ff;
      rsp_valid    = rsp_valid_ff;
      rsp_data     = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_COPY;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with an empty stage");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_hold) |=> rsp_valid)
      else $error("request lost between stages");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (mode_ff == $past(csr_write_data)))
      else $error("mode register not updated");

endmodule

`default_nettype wire

@@ rtl/rpb_color_mix.sv @@
// One colour channel of the blend datapath (combinational).
// Depends on rpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpb_color_mix import rpb_pkg::*; (
   input  wire logic [MODE_W-1:0] mode,
   input  wire logic [CHAN_W-1:0] dst,
   input  wire logic [CHAN_W-1:0] dst_alpha,
   input  wire logic [CHAN_W-1:0] src,
   input  wire logic [CHAN_W-1:0] src_alpha,
   output logic      [CHAN_W-1:0] result
);

   logic [2*CHAN_W-1:0] src_term;
   logic [2*CHAN_W-1:0] dst_term;
   logic [2*CHAN_W-1:0] blend_sum;
   logic [2*CHAN_W-1:0] dst_premul;
   logic [2*CHAN_W-1:0] mul_prod;
   logic [CHAN_W-1:0]   dst_scaled;
   logic [CHAN_W:0]     add_sum;

   always_comb begin
      src_term   = {{CHAN_W{1'b0}}, src_alpha} * {{CHAN_W{1'b0}}, src};
      dst_term   = {{CHAN_W{1'b0}}, CHAN_MAX - src_alpha} * {{CHAN_W{1'b0}}, dst};
      // sum never exceeds 255*255
      blend_sum  = src_term + dst_term;
      dst_premul = {{CHAN_W{1'b0}}, dst_alpha} * {{CHAN_W{1'b0}}, dst};
      mul_prod   = {{CHAN_W{1'b0}}, dst} * {{CHAN_W{1'b0}}, src};
      dst_scaled = div255(dst_premul);
      add_sum    = {1'b0, dst_scaled} + {1'b0, src};
      case (mode)
         MODE_ALPHA:    result = div255(blend_sum);
         MODE_ADD:      result = add_sum[CHAN_W] ? CHAN_MAX : add_sum[CHAN_W-1:0];
         MODE_SUBTRACT: result = (dst_scaled > src) ? dst_scaled - src : '0;
         MODE_MULTIPLY: result = div255(mul_prod);
         default:       result = src;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/rpb_alpha_mix.sv @@
// Alpha channel of the blend datapath (combinational).
// Depends on rpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpb_alpha_mix import rpb_pkg::*; (
   input  wire logic [MODE_W-1:0] mode,
   input  wire logic [CHAN_W-1:0] dst_alpha,
   input  wire logic [CHAN_W-1:0] src_alpha,
   output logic      [CHAN_W-1:0] result
);

   logic [2*CHAN_W-1:0] alpha_prod;
   logic [CHAN_W:0]     alpha_sum;

   always_comb begin
      alpha_prod = {{CHAN_W{1'b0}}, dst_alpha} * {{CHAN_W{1'b0}}, src_alpha};
      alpha_sum  = {1'b0, dst_alpha} + {1'b0, src_alpha};
      case (mode)
         MODE_ALPHA:    result = (alpha_prod[2*CHAN_W-1:CHAN_W] != '0) ? CHAN_MAX
                                 : alpha_prod[CHAN_W-1:0];
         MODE_ADD:      result = alpha_sum[CHAN_W] ? CHAN_MAX : alpha_sum[CHAN_W-1:0];
         MODE_SUBTRACT: result = (dst_alpha > src_alpha) ? dst_alpha - src_alpha : '0;
         MODE_MULTIPLY: result = div255(alpha_prod);
         default:       result = src_alpha;
      endcase
   end

endmodule

`default_nettype wire
